// File: design/xcfr_pkg.sv
package xcfr_pkg;

    localparam int MAX_PAYLOAD = 32;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAME_LEN_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_SEED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;

    localparam logic [7:0]  BCAST_RESET   = 8'hFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_FLAG_LO  = 3'd0,
        PH_FLAG_HI  = 3'd1,
        PH_SRC      = 3'd2,
        PH_DST      = 3'd3,
        PH_LEN      = 3'd4,
        PH_PAYLOAD  = 3'd5,
        PH_CHECK    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_SHOW = 2'd2
    } t_back_st;

    typedef struct packed {
        logic [15:0] start_flag;
        logic [7:0]  own_address;
        logic [7:0]  broadcast_address;
        logic [7:0]  checksum_seed;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0] src;
        logic [7:0] dst;
    } t_frm_hdr;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// File: design/xcfr_if.sv
interface xcfr_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface xcfr_out_if;
    logic                               valid;
    logic                               ready;
    logic [7:0]                         source_address;
    logic [7:0]                         destination_address;
    logic [xcfr_pkg::FRAME_LEN_W-1:0]   frame_length;
    logic [7:0]                         payload_byte;
    logic                               empty_frame;
    logic                               last_byte;

    modport source (output valid, output source_address, output destination_address,
                    output frame_length, output payload_byte, output empty_frame,
                    output last_byte, input ready);
    modport sink   (input valid, input source_address, input destination_address,
                    input frame_length, input payload_byte, input empty_frame,
                    input last_byte, output ready);
endinterface

// File: design/xcfr_front.sv
module xcfr_front #(
    parameter int MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD,
    localparam int LW = $clog2(MAX_PAYLOAD + 1),
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    xcfr_in_if.sink               i_in,
    input  xcfr_pkg::t_cfg        i_cfg,
    input  logic                  i_q_full,
    output logic                  o_push,
    output xcfr_pkg::t_frm_hdr    o_hdr,
    output logic [LW-1:0]         o_len,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_idx,
    output logic [7:0]            o_mem_data
);
    xcfr_pkg::t_phase r_phase, n_phase;
    logic [LW-1:0]    r_count, n_count;
    logic [15:0]      r_timer, n_timer;
    logic [7:0]       r_first, n_first;
    logic [7:0]       r_src, n_src;
    logic [7:0]       r_dst, n_dst;
    logic [LW-1:0]    r_len, n_len;
    logic [7:0]       r_ck, n_ck;

    logic             acc;
    logic             in_frame;

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && i_in.ready;
    assign in_frame   = (r_phase != xcfr_pkg::PH_FLAG_LO) && (r_phase != xcfr_pkg::PH_FLAG_HI);

    assign o_hdr.src  = r_src;
    assign o_hdr.dst  = r_dst;
    assign o_len      = r_len;
    assign o_mem_idx  = r_count[AW-1:0];
    assign o_mem_data = i_in.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcfr_pkg::PH_FLAG_LO;
            r_count <= '0;
            r_timer <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_timer <= n_timer;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first <= n_first;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_len   <= n_len;
        r_ck    <= n_ck;
    end

    always_comb begin
        logic [15:0] v_tick;
        v_tick   = (r_timer != xcfr_pkg::TIMER_MAX) ? r_timer + 16'd1 : r_timer;
        n_phase  = r_phase;
        n_count  = r_count;
        n_timer  = r_timer;
        n_first  = r_first;
        n_src    = r_src;
        n_dst    = r_dst;
        n_len    = r_len;
        n_ck     = r_ck;
        o_push   = 1'b0;
        o_mem_we = 1'b0;
        if (acc && i_in.cmd) begin
            if (in_frame) begin
                n_timer = v_tick;
                if (v_tick >= i_cfg.timeout_ticks) begin
                    n_phase = xcfr_pkg::PH_FLAG_LO;
                    n_count = '0;
                    n_timer = '0;
                end
            end
        end else if (acc) begin
            case (r_phase)
                xcfr_pkg::PH_FLAG_LO: begin
                    n_first = i_in.rx_byte;
                    n_phase = xcfr_pkg::PH_FLAG_HI;
                end
                xcfr_pkg::PH_FLAG_HI: begin
                    if (r_first == i_cfg.start_flag[7:0] &&
                        i_in.rx_byte == i_cfg.start_flag[15:8]) begin
                        n_ck    = i_cfg.checksum_seed ^ r_first ^ i_in.rx_byte;
                        n_phase = xcfr_pkg::PH_SRC;
                        n_timer = '0;
                    end else begin
                        n_phase = xcfr_pkg::PH_FLAG_LO;
                    end
                end
                xcfr_pkg::PH_SRC: begin
                    n_src   = i_in.rx_byte;
                    n_ck    = r_ck ^ i_in.rx_byte;
                    n_phase = xcfr_pkg::PH_DST;
                end
                xcfr_pkg::PH_DST: begin
                    n_dst   = i_in.rx_byte;
                    n_ck    = r_ck ^ i_in.rx_byte;
                    n_phase = xcfr_pkg::PH_LEN;
                end
                xcfr_pkg::PH_LEN: begin
                    if (i_in.rx_byte > 8'(MAX_PAYLOAD)) begin
                        n_phase = xcfr_pkg::PH_FLAG_LO;
                        n_count = '0;
                        n_timer = '0;
                    end else begin
                        n_len   = i_in.rx_byte[LW-1:0];
                        n_ck    = r_ck ^ i_in.rx_byte;
                        n_count = '0;
                        n_timer = '0;
                        n_phase = (i_in.rx_byte == 8'd0) ? xcfr_pkg::PH_CHECK
                                                         : xcfr_pkg::PH_PAYLOAD;
                    end
                end
                xcfr_pkg::PH_PAYLOAD: begin
                    o_mem_we = 1'b1;
                    n_ck     = r_ck ^ i_in.rx_byte;
                    n_count  = r_count + 1'b1;
                    if (n_count >= r_len) begin
                        n_phase = xcfr_pkg::PH_CHECK;
                    end
                end
                xcfr_pkg::PH_CHECK: begin
                    n_phase = xcfr_pkg::PH_FLAG_LO;
                    n_count = '0;
                    n_timer = '0;
                    o_push  = (i_in.rx_byte == r_ck) &&
                              (r_dst == i_cfg.broadcast_address ||
                               r_dst == i_cfg.own_address);
                end
                default: begin
                    n_phase = xcfr_pkg::PH_FLAG_LO;
                    n_count = '0;
                    n_timer = '0;
                end
            endcase
        end
    end

endmodule

// File: design/xcfr_queue.sv
module xcfr_queue #(
    parameter int MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD,
    localparam int LW = $clog2(MAX_PAYLOAD + 1),
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  xcfr_pkg::t_frm_hdr    i_hdr,
    input  logic [LW-1:0]         i_len,
    input  logic                  i_pop,
    output xcfr_pkg::t_q_stat     o_stat,
    output xcfr_pkg::t_frm_hdr    o_hdr,
    output logic [LW-1:0]         o_len,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_widx,
    input  logic [7:0]            i_wdata,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_ridx,
    output logic [7:0]            o_rdata
);
    // one payload bank per descriptor slot
    logic [7:0]          r_mem [0:(2**(AW+1))-1];
    logic [7:0]          r_rdata;
    xcfr_pkg::t_frm_hdr  r_hdr [0:1];
    logic [LW-1:0]       r_len [0:1];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;

    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.full  = (r_count == 2'd2);
    assign o_hdr        = r_hdr[r_rd_ptr];
    assign o_len        = r_len[r_rd_ptr];
    assign o_rdata      = r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_hdr[r_wr_ptr] <= i_hdr;
            r_len[r_wr_ptr] <= i_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[{r_wr_ptr, i_widx}] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[{r_rd_ptr, i_ridx}];
        end
    end

endmodule

// File: design/xcfr_back.sv
module xcfr_back #(
    parameter int MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD,
    localparam int LW = $clog2(MAX_PAYLOAD + 1),
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  xcfr_pkg::t_q_stat     i_q,
    input  xcfr_pkg::t_frm_hdr    i_hdr,
    input  logic [LW-1:0]         i_len,
    output logic                  o_pop,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_idx,
    input  logic [7:0]            i_rd_data,
    xcfr_out_if.source            o_out
);
    xcfr_pkg::t_back_st r_state, n_state;
    logic [LW-1:0]      r_idx, n_idx;
    logic               empty;
    logic               last;

    assign empty    = (i_len == '0);
    assign last     = empty || ((r_idx + 1'b1) == i_len);
    assign o_rd_idx = r_idx[AW-1:0];

    assign o_out.source_address      = i_hdr.src;
    assign o_out.destination_address = i_hdr.dst;
    assign o_out.frame_length        = xcfr_pkg::FRAME_LEN_W'(i_len);
    assign o_out.payload_byte        = empty ? 8'd0 : i_rd_data;
    assign o_out.empty_frame         = empty;
    assign o_out.last_byte           = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xcfr_pkg::BK_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_pop       = 1'b0;
        o_rd_en     = 1'b0;
        o_out.valid = 1'b0;
        case (r_state)
            xcfr_pkg::BK_IDLE: begin
                if (!i_q.empty) begin
                    n_idx   = '0;
                    n_state = xcfr_pkg::BK_READ;
                end
            end
            xcfr_pkg::BK_READ: begin
                o_rd_en = 1'b1;
                n_state = xcfr_pkg::BK_SHOW;
            end
            xcfr_pkg::BK_SHOW: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    if (last) begin
                        o_pop   = 1'b1;
                        n_state = xcfr_pkg::BK_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = xcfr_pkg::BK_READ;
                    end
                end
            end
            default: begin
                n_state = xcfr_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

// File: design/xor_checked_frame_receiver.sv
// Frame receiver: takes one input beat per cycle (received byte or millisecond tick), hunts the
// two-byte start flag, checks length, timeout, XOR checksum and destination, and buffers the
// payload. Good frames go into a two-deep frame queue with one payload bank per entry; the
// input stalls only while both entries hold frames not yet sent. Each result beat first reads
// the payload buffer, then shows the registered read data; the next beat's read waits until
// that beat is accepted. No clearing pass after reset.
module xor_checked_frame_receiver #(
    parameter int MAX_PAYLOAD = xcfr_pkg::MAX_PAYLOAD
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    xcfr_in_if.sink                           i_in,
    xcfr_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [xcfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int LW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    xcfr_pkg::t_cfg      r_cfg;
    xcfr_pkg::t_q_stat   q_stat;
    xcfr_pkg::t_frm_hdr  push_hdr;
    xcfr_pkg::t_frm_hdr  head_hdr;
    logic [LW-1:0]       push_len;
    logic [LW-1:0]       head_len;
    logic                push;
    logic                pop;
    logic                mem_we;
    logic [AW-1:0]       mem_widx;
    logic [7:0]          mem_wdata;
    logic                rd_en;
    logic [AW-1:0]       rd_idx;
    logic [7:0]          rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_flag        <= '0;
            r_cfg.own_address       <= '0;
            r_cfg.broadcast_address <= xcfr_pkg::BCAST_RESET;
            r_cfg.checksum_seed     <= '0;
            r_cfg.timeout_ticks     <= xcfr_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                xcfr_pkg::CFG_START_FLAG: r_cfg.start_flag        <= i_cfg_data;
                xcfr_pkg::CFG_OWN_ADDR:   r_cfg.own_address       <= i_cfg_data[7:0];
                xcfr_pkg::CFG_BCAST_ADDR: r_cfg.broadcast_address <= i_cfg_data[7:0];
                xcfr_pkg::CFG_CHECK_SEED: r_cfg.checksum_seed     <= i_cfg_data[7:0];
                xcfr_pkg::CFG_TIMEOUT:    r_cfg.timeout_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    xcfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (r_cfg),
        .i_q_full   (q_stat.full),
        .o_push     (push),
        .o_hdr      (push_hdr),
        .o_len      (push_len),
        .o_mem_we   (mem_we),
        .o_mem_idx  (mem_widx),
        .o_mem_data (mem_wdata)
    );

    xcfr_queue #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_hdr   (push_hdr),
        .i_len   (push_len),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_hdr   (head_hdr),
        .o_len   (head_len),
        .i_we    (mem_we),
        .i_widx  (mem_widx),
        .i_wdata (mem_wdata),
        .i_rd_en (rd_en),
        .i_ridx  (rd_idx),
        .o_rdata (rd_data)
    );

    xcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q       (q_stat),
        .i_hdr     (head_hdr),
        .i_len     (head_len),
        .o_pop     (pop),
        .o_rd_en   (rd_en),
        .o_rd_idx  (rd_idx),
        .i_rd_data (rd_data),
        .o_out     (o_out)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("frame pushed into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("frame popped from empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> !q_stat.empty)
        else $error("pushed frame missing from queue");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.empty_frame |-> o_out.last_byte && o_out.payload_byte == 8'd0)
        else $error("empty frame beat malformed");

endmodule

// File: tb/xor_checked_frame_receiver_tb.sv
`timescale 1ns / 100ps

module xor_checked_frame_receiver_tb;
    import xcfr_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_GUARD   = 20000;
    localparam int LONG_STALL    = 400;
    localparam int SET_BYTES     = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_rx_beat;

    typedef struct packed {
        logic [7:0]             src;
        logic [7:0]             dst;
        logic [FRAME_LEN_W-1:0] len;
        logic [7:0]             data;
        logic                   empty;
        logic                   last;
    } t_frame_beat;

    typedef struct packed {
        t_phase                      phase;
        logic [7:0]                  flag_lo;
        logic [5:0]                  count;
        logic [15:0]                 timer;
        logic [7:0]                  src;
        logic [7:0]                  dst;
        logic [5:0]                  len;
        logic [7:0]                  sum;
        logic [MAX_PAYLOAD-1:0][7:0] store;
    } t_rx_state;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    xcfr_in_if  in_bus ();
    xcfr_out_if out_bus ();

    xor_checked_frame_receiver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_rx_beat    rx_beats_q[$];
    t_frame_beat frame_bytes_due[$];
    t_cfg        link_cfg;
    t_rx_state   link_st;
    t_rx_state   plan_st;
    logic [7:0]  tx_sum;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          stall_len;
    int          stall_seq;
    int          stall_seen;
    int          stall_left;
    int          bytes_queued;
    int          err_cnt;
    bit          in_taken;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void drop_frame(inout t_rx_state st);
        st.phase = PH_FLAG_LO;
        st.count = '0;
        st.timer = '0;
    endfunction

    // deframer step; link_st tracks the DUT, plan_st tracks the stimulus stream
    function automatic void deframe(inout t_rx_state st, input logic cmd, input logic [7:0] b,
                                    input bit emit);
        logic        ok;
        t_frame_beat r;
        int          k;
        if (cmd) begin
            if (st.phase >= PH_SRC && st.phase <= PH_CHECK) begin
                if (st.timer != TIMER_MAX)
                    st.timer++;
                if (st.timer >= link_cfg.timeout_ticks)
                    drop_frame(st);
            end
            return;
        end
        case (st.phase)
            PH_FLAG_LO: begin
                st.flag_lo = b;
                st.phase   = PH_FLAG_HI;
            end
            PH_FLAG_HI: begin
                if (st.flag_lo == link_cfg.start_flag[7:0] &&
                    b == link_cfg.start_flag[15:8]) begin
                    st.sum   = link_cfg.checksum_seed ^ st.flag_lo ^ b;
                    st.phase = PH_SRC;
                    st.timer = '0;
                end else begin
                    st.phase = PH_FLAG_LO;
                end
            end
            PH_SRC: begin
                st.src   = b;
                st.sum  ^= b;
                st.phase = PH_DST;
            end
            PH_DST: begin
                st.dst   = b;
                st.sum  ^= b;
                st.phase = PH_LEN;
            end
            PH_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    drop_frame(st);
                end else begin
                    st.len   = b[5:0];
                    st.sum  ^= b;
                    st.count = '0;
                    st.timer = '0;
                    st.phase = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (st.count < MAX_PAYLOAD)
                    st.store[st.count] = b;
                st.sum ^= b;
                st.count++;
                if (st.count >= st.len)
                    st.phase = PH_CHECK;
            end
            PH_CHECK: begin
                ok = (b == st.sum) && (st.dst == link_cfg.broadcast_address ||
                                       st.dst == link_cfg.own_address);
                drop_frame(st);
                if (ok && emit) begin
                    r.src = st.src;
                    r.dst = st.dst;
                    if (st.len == 6'd0) begin
                        r.len   = '0;
                        r.data  = 8'h00;
                        r.empty = 1'b1;
                        r.last  = 1'b1;
                        frame_bytes_due.push_back(r);
                    end else begin
                        for (k = 0; k < int'(st.len); k++) begin
                            r.len   = st.len;
                            r.data  = st.store[k];
                            r.empty = 1'b0;
                            r.last  = (k + 1 == int'(st.len));
                            frame_bytes_due.push_back(r);
                        end
                    end
                end
            end
            default: drop_frame(st);
        endcase
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // monitor: predict on accepted input beats, check accepted result beats
    always @(posedge i_clk) begin
        t_frame_beat want;
        in_taken = i_rst_n && in_bus.valid && in_bus.ready;
        if (in_taken)
            deframe(link_st, in_bus.cmd, in_bus.rx_byte, 1'b1);
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (frame_bytes_due.size() == 0) begin
                $display("%0t: extra result, expected none, actual %h %h %0d %h %b %b",
                         $time, out_bus.source_address, out_bus.destination_address,
                         out_bus.frame_length, out_bus.payload_byte, out_bus.empty_frame,
                         out_bus.last_byte);
                err_cnt++;
            end else begin
                want = frame_bytes_due[0];
                frame_bytes_due.delete(0);
                check_field("source_address", want.src, out_bus.source_address);
                check_field("destination_address", want.dst, out_bus.destination_address);
                check_field("frame_length", 8'(want.len), 8'(out_bus.frame_length));
                check_field("payload_byte", want.data, out_bus.payload_byte);
                check_field("empty_frame", 8'(want.empty), 8'(out_bus.empty_frame));
                check_field("last_byte", 8'(want.last), 8'(out_bus.last_byte));
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (in_taken)
            rx_beats_q.delete(0);
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            if (rx_beats_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_bus.valid   <= 1'b1;
                in_bus.cmd     <= rx_beats_q[0].cmd;
                in_bus.rx_byte <= rx_beats_q[0].data;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result sink with optional long hold-off
    always @(negedge i_clk) begin
        if (stall_seq != stall_seen) begin
            stall_seen = stall_seq;
            stall_left = stall_len;
        end
        if (stall_left != 0) begin
            stall_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic push_beat(input logic cmd, input logic [7:0] b);
        t_rx_beat beat;
        beat.cmd  = cmd;
        beat.data = b;
        rx_beats_q.push_back(beat);
        deframe(plan_st, cmd, b, 1'b0);
        if (!cmd)
            bytes_queued++;
    endtask

    task automatic push_data(input logic [7:0] b);
        push_beat(1'b0, b);
        tx_sum ^= b;
    endtask

    task automatic tick_gap(input int pct);
        if ($urandom_range(99) < pct)
            repeat ($urandom_range(1, 2)) push_beat(1'b1, 8'($urandom));
    endtask

    // fill until the stream is back at a flag boundary, then send the flag
    task automatic push_flag;
        while (plan_st.phase != PH_FLAG_LO)
            push_beat(1'b0, 8'($urandom));
        tx_sum = link_cfg.checksum_seed;
        push_data(link_cfg.start_flag[7:0]);
        push_data(link_cfg.start_flag[15:8]);
    endtask

    task automatic send_frame(input logic [7:0] src, input logic [7:0] dst, input int len,
                              input bit bad_sum, input int tick_pct);
        int k;
        push_flag();
        tick_gap(tick_pct);
        push_data(src);
        tick_gap(tick_pct);
        push_data(dst);
        tick_gap(tick_pct);
        push_data(8'(len));
        if (len <= MAX_PAYLOAD) begin
            for (k = 0; k < len; k++) begin
                tick_gap(tick_pct);
                push_data(8'($urandom));
            end
            tick_gap(tick_pct);
            push_beat(1'b0, tx_sum ^ (bad_sum ? 8'($urandom_range(255, 1)) : 8'h00));
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_START_FLAG: link_cfg.start_flag        = val;
            CFG_OWN_ADDR:   link_cfg.own_address       = val[7:0];
            CFG_BCAST_ADDR: link_cfg.broadcast_address = val[7:0];
            CFG_CHECK_SEED: link_cfg.checksum_seed     = val[7:0];
            CFG_TIMEOUT:    link_cfg.timeout_ticks     = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle;
        int guard;
        guard = 0;
        while ((rx_beats_q.size() != 0 || in_bus.valid || frame_bytes_due.size() != 0) &&
               guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_octet();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic shuffle_cfg;
        logic [15:0] tmo;
        case ($urandom_range(5))
            0:       tmo = 16'd1;
            1:       tmo = 16'd2;
            2:       tmo = 16'd3;
            3:       tmo = 16'($urandom_range(40, 4));
            4:       tmo = TIMEOUT_RESET;
            default: tmo = TIMER_MAX;
        endcase
        cfg_write(CFG_START_FLAG, {pick_octet(), pick_octet()});
        cfg_write(CFG_OWN_ADDR, 16'(pick_octet()));
        cfg_write(CFG_BCAST_ADDR, 16'(pick_octet()));
        cfg_write(CFG_CHECK_SEED, 16'(pick_octet()));
        cfg_write(CFG_TIMEOUT, tmo);
    endtask

    task automatic random_traffic(input int n_bytes);
        int         stop_at;
        int         r;
        int         len;
        int         tick_pct;
        logic [7:0] dst;
        stop_at  = bytes_queued + n_bytes;
        tick_pct = (link_cfg.timeout_ticks <= 16'd3) ? 6 : 12;
        while (bytes_queued < stop_at) begin
            r = $urandom_range(99);
            if (r < 5) begin
                repeat ($urandom_range(1, 3)) push_beat(1'b0, 8'($urandom));
            end else if (r < 8) begin
                push_beat(1'b0, ~link_cfg.start_flag[7:0]);
                push_beat(1'b0, link_cfg.start_flag[15:8]);
            end else if (r < 11) begin
                repeat ($urandom_range(1, 4)) push_beat(1'b1, 8'($urandom));
            end else if (r < 15) begin
                // truncated frame
                push_flag();
                push_data(8'($urandom));
                if ($urandom_range(1) == 1)
                    push_data(8'($urandom));
            end else begin
                r = $urandom_range(99);
                if (r < 45)
                    dst = link_cfg.own_address;
                else if (r < 80)
                    dst = link_cfg.broadcast_address;
                else
                    dst = 8'($urandom);
                r = $urandom_range(99);
                if (r < 8)
                    len = 0;
                else if (r < 70)
                    len = $urandom_range(6, 1);
                else if (r < 88)
                    len = $urandom_range(31, 7);
                else if (r < 93)
                    len = MAX_PAYLOAD;
                else
                    len = $urandom_range(255, MAX_PAYLOAD + 1);
                send_frame(8'($urandom), dst, len, ($urandom_range(9) == 0), tick_pct);
            end
        end
    endtask

    initial begin
        int mode;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_bus.valid   = 1'b0;
        in_bus.cmd     = 1'b0;
        in_bus.rx_byte = 8'h00;
        out_bus.ready  = 1'b0;
        src_idle_pct   = 12;
        snk_idle_pct   = 52;
        stall_len      = 0;
        stall_seq      = 0;
        stall_seen     = 0;
        stall_left     = 0;
        bytes_queued   = 0;
        err_cnt        = 0;
        in_taken       = 1'b0;
        tx_sum         = 8'h00;
        link_st        = '0;
        plan_st        = '0;
        link_cfg.start_flag        = 16'h0000;
        link_cfg.own_address       = 8'h00;
        link_cfg.broadcast_address = BCAST_RESET;
        link_cfg.checksum_seed     = 8'h00;
        link_cfg.timeout_ticks     = TIMEOUT_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        push_beat(1'b1, 8'h5A);
        send_frame(8'hFF, 8'h00, 0, 1'b0, 0);
        send_frame(8'h00, 8'hFF, 1, 1'b0, 0);
        send_frame(8'h3C, 8'h00, 2, 1'b1, 0);
        send_frame(8'h11, 8'h55, 0, 1'b0, 0);
        send_frame(8'h22, 8'h00, MAX_PAYLOAD + 1, 1'b0, 0);
        send_frame(8'h23, 8'hFF, 255, 1'b0, 0);
        push_beat(1'b0, 8'h01);
        push_beat(1'b0, 8'h00);
        wait_idle();

        cfg_write(CFG_START_FLAG, 16'hFFFF);
        cfg_write(CFG_OWN_ADDR, 16'h0012);
        cfg_write(CFG_BCAST_ADDR, 16'h0000);
        cfg_write(CFG_CHECK_SEED, 16'h00FF);
        cfg_write(CFG_TIMEOUT, 16'd1);
        cfg_write(CFG_SPARE, 16'(pick_octet()));
        send_frame(8'h01, 8'h12, 3, 1'b0, 0);
        send_frame(8'h02, 8'h00, 1, 1'b0, 0);
        // one tick in the header drops the frame
        push_flag();
        push_data(8'h03);
        push_beat(1'b1, 8'hFF);
        send_frame(8'h04, 8'h12, 0, 1'b0, 0);
        wait_idle();

        cfg_write(CFG_TIMEOUT, 16'd2);
        // timer restarts at the length byte
        push_flag();
        push_data(8'h05);
        push_beat(1'b1, 8'h00);
        push_data(8'h12);
        push_data(8'h01);
        push_beat(1'b1, 8'hFF);
        push_data(8'hC3);
        push_beat(1'b0, tx_sum);
        // payload/checksum phase runs out
        push_flag();
        push_data(8'h06);
        push_data(8'h12);
        push_data(8'h01);
        push_data(8'h99);
        push_beat(1'b1, 8'h00);
        push_beat(1'b1, 8'hFF);
        // register writes in the middle of a frame
        push_flag();
        push_data(8'h07);
        wait_idle();
        cfg_write(CFG_CHECK_SEED, 16'h0000);
        cfg_write(CFG_OWN_ADDR, 16'h0040);
        push_data(8'h40);
        push_data(8'h00);
        push_beat(1'b0, tx_sum);
        wait_idle();
        cfg_write(CFG_TIMEOUT, TIMER_MAX);
        send_frame(8'h08, 8'h40, 5, 1'b0, 30);
        wait_idle();

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    src_idle_pct = 12;
                    snk_idle_pct = 52;
                end
                1: begin
                    src_idle_pct = 52;
                    snk_idle_pct = 12;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            if (mode == 1) begin
                // sink holds off while frames keep coming, input must back up
                stall_len = LONG_STALL;
                stall_seq++;
                repeat (4) send_frame(8'($urandom), link_cfg.own_address,
                                      $urandom_range(12, 8), 1'b0, 0);
                send_frame(8'($urandom), link_cfg.own_address, MAX_PAYLOAD, 1'b0, 0);
                wait_idle();
            end
            repeat (2) begin
                shuffle_cfg();
                random_traffic(SET_BYTES);
                wait_idle();
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (frame_bytes_due.size() != 0) begin
            $display("%0t: %0d results missing, expected src %h dst %h data %h, actual none",
                     $time, frame_bytes_due.size(), frame_bytes_due[0].src,
                     frame_bytes_due[0].dst, frame_bytes_due[0].data);
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("xor_checked_frame_receiver_tb: clean");
        else
            $display("xor_checked_frame_receiver_tb: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("xor_checked_frame_receiver_tb: errors");
        $finish;
    end

endmodule
